[hdl/qtnp_pkg.sv]
// Shared types, constants and helpers for the quadtree node placement block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package qtnp_pkg;

    // Deepest tree the chain is built for; one cell per level.
    localparam int MAX_DEPTH = 8;

    // Field widths of the external interface.
    localparam int FIELD_W  = 24;
    localparam int LVL_W    = 4;
    localparam int PATH_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Coordinates carry MAX_DEPTH extra fraction bits so every halving is exact.
    // The three guard bits cover edge sums of a signed origin and an unsigned extent.
    localparam int CW = FIELD_W + MAX_DEPTH + 3;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOT_X      = 3'd0,
        REG_ROOT_Y      = 3'd1,
        REG_ROOT_WIDTH  = 3'd2,
        REG_ROOT_HEIGHT = 3'd3,
        REG_DEPTH_LIMIT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CHILD_TL = 2'd0,
        CHILD_TR = 2'd1,
        CHILD_BL = 2'd2,
        CHILD_BR = 2'd3
    } child_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rect_x;
        logic signed [FIELD_W-1:0] rect_y;
        logic        [FIELD_W-1:0] rect_width;
        logic        [FIELD_W-1:0] rect_height;
    } in_beat_t;

    typedef struct packed {
        logic              placed;
        logic [LVL_W-1:0]  node_level;
        logic [PATH_W-1:0] node_path;
    } out_beat_t;

    // One rectangle in flight along the chain of cells.
    typedef struct packed {
        logic              done;
        logic              placed;
        logic [LVL_W-1:0]  level;
        logic [PATH_W-1:0] path;
        coord_t            rx;
        coord_t            ry;
        coord_t            rr;
        coord_t            rt;
        coord_t            nx;
        coord_t            ny;
        coord_t            nw;
        coord_t            nh;
    } item_t;

    function automatic coord_t scale_s(input logic [FIELD_W-1:0] v);
        coord_t t;
        t = {{(CW-FIELD_W){v[FIELD_W-1]}}, v};
        return t <<< MAX_DEPTH;
    endfunction

    function automatic coord_t scale_u(input logic [FIELD_W-1:0] v);
        coord_t t;
        t = {{(CW-FIELD_W){1'b0}}, v};
        return t <<< MAX_DEPTH;
    endfunction

endpackage

`default_nettype wire

[hdl/quadtree_node_placement_top.sv]
// Top level of the quadtree node placement block: configuration registers,
// input scaling, the chain of per-level cells and the output register. Depends on qtnp_pkg, qtnp_cell.
`default_nettype none

//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_beat  (in_beat_t: rect_x, rect_y, width, height)
//  m_        out        m_valid / m_ready    m_beat  (out_beat_t: placed, node_level, node_path)
//  cfg_      in         cfg_we, no wait      cfg_addr selects the register, cfg_wdata the value
//
//  One rectangle beat is taken per cycle while the result side keeps up. Each beat
//  passes through one cell of the chain per tree level and then the output register.
//  Reset is synchronous and active low; it empties the chain and restores the register
//  defaults. A stall on m_ready holds the output register, and each cell keeps taking
//  beats as long as it or its downstream neighbor has room, so bubbles close up.

module quadtree_node_placement_top
    import qtnp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_beat,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_beat,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [FIELD_W-1:0]   cfg_wdata
);

    // Configuration registers. The user must change them only while the block is idle;
    // the block does not enforce it. Beats carry the root box; cells read the depth limit directly.
    logic [FIELD_W-1:0] root_x_reg;
    logic [FIELD_W-1:0] root_y_reg;
    logic [FIELD_W-1:0] root_width_reg;
    logic [FIELD_W-1:0] root_height_reg;
    logic [LVL_W-1:0]   depth_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_x_reg      <= '0;
            root_y_reg      <= '0;
            root_width_reg  <= FIELD_W'(262144);
            root_height_reg <= FIELD_W'(262144);
            depth_limit_reg <= LVL_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ROOT_X:      root_x_reg      <= cfg_wdata;
                REG_ROOT_Y:      root_y_reg      <= cfg_wdata;
                REG_ROOT_WIDTH:  root_width_reg  <= cfg_wdata;
                REG_ROOT_HEIGHT: root_height_reg <= cfg_wdata;
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // A depth limit beyond the chain length saturates at the chain length.
    logic [LVL_W-1:0] depth_lim;
    assign depth_lim = (int'(depth_limit_reg) > MAX_DEPTH) ? LVL_W'(MAX_DEPTH)
                                                           : depth_limit_reg;

    // Scale the rectangle and the root box into the widened coordinate space and
    // form the rectangle's right and top edges once for the whole chain.
    item_t front_item;

    always_comb begin
        front_item        = '0;
        front_item.rx     = scale_s(s_beat.rect_x);
        front_item.ry     = scale_s(s_beat.rect_y);
        front_item.rr     = front_item.rx + scale_u(s_beat.rect_width);
        front_item.rt     = front_item.ry + scale_u(s_beat.rect_height);
        front_item.nx     = scale_s(root_x_reg);
        front_item.ny     = scale_s(root_y_reg);
        front_item.nw     = scale_u(root_width_reg);
        front_item.nh     = scale_u(root_height_reg);
    end

    // Chain of cells; cell k decides the step from level k to level k + 1.
    item_t stage_item  [0:MAX_DEPTH];
    logic  stage_valid [0:MAX_DEPTH];
    logic  stage_ready [0:MAX_DEPTH];

    assign stage_item[0]  = front_item;
    assign stage_valid[0] = s_valid;
    assign s_ready        = stage_ready[0];

    for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
        qtnp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lvl_idx   (LVL_W'(k)),
            .depth_lim (depth_lim),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    // Output register. An item still open after the last cell sits at the deepest
    // level and is placed there without a check. A dropped item reports the root
    // with an empty path.
    logic      m_valid_reg;
    logic      m_valid_next;
    out_beat_t m_beat_reg;
    out_beat_t m_beat_next;
    item_t     last_item;

    assign last_item                 = stage_item[MAX_DEPTH];
    assign stage_ready[MAX_DEPTH]    = !m_valid_reg || m_ready;

    always_comb begin
        m_beat_next.placed     = last_item.done ? last_item.placed : 1'b1;
        m_beat_next.node_level = m_beat_next.placed ? last_item.level : '0;
        m_beat_next.node_path  = m_beat_next.placed ? last_item.path  : '0;

        m_valid_next = m_valid_reg;
        if (stage_ready[MAX_DEPTH]) begin
            m_valid_next = stage_valid[MAX_DEPTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[MAX_DEPTH] && stage_valid[MAX_DEPTH]) begin
            m_beat_reg <= m_beat_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

endmodule

`default_nettype wire

[hdl/qtnp_cell.sv]
// One tree level of the placement chain: tests the four children and registers the item.
// Depends on qtnp_pkg.
`default_nettype none

module qtnp_cell
    import qtnp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [LVL_W-1:0] lvl_idx,
    input  wire logic [LVL_W-1:0] depth_lim,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire item_t            in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output item_t                 out_item
);

    logic   valid_reg;
    logic   valid_next;
    item_t  item_reg;
    item_t  item_next;

    coord_t kw, kh, xm, xr, ym, yt, nr, nt;
    logic   fx_l, fx_r, fy_t, fy_b;
    logic   entered;
    logic   node_fits;
    child_t code;

    assign in_ready = !valid_reg || out_ready;

    // The rectangle's width and height are never negative, so each containment test
    // reduces to the left, bottom, right and top edge comparisons.
    always_comb begin
        kw = in_item.nw >>> 1;
        kh = in_item.nh >>> 1;
        xm = in_item.nx + kw;
        xr = xm + kw;
        ym = in_item.ny + kh;
        yt = ym + kh;
        nr = in_item.nx + in_item.nw;
        nt = in_item.ny + in_item.nh;

        fx_l = (in_item.rx >= in_item.nx) && (in_item.rr <= xm);
        fx_r = (in_item.rx >= xm)         && (in_item.rr <= xr);
        fy_t = (in_item.ry >= ym)         && (in_item.rt <= yt);
        fy_b = (in_item.ry >= in_item.ny) && (in_item.rt <= ym);

        node_fits = (in_item.rx >= in_item.nx) && (in_item.ry >= in_item.ny) &&
                    (in_item.rr <= nr) && (in_item.rt <= nt);

        entered = 1'b1;
        if (fx_l && fy_t) begin
            code = CHILD_TL;
        end else if (fx_r && fy_t) begin
            code = CHILD_TR;
        end else if (fx_l && fy_b) begin
            code = CHILD_BL;
        end else if (fx_r && fy_b) begin
            code = CHILD_BR;
        end else begin
            code    = CHILD_TL;
            entered = 1'b0;
        end

        item_next = in_item;
        if (in_item.done) begin
            item_next = in_item;
        end else if (lvl_idx >= depth_lim) begin
            item_next.done   = 1'b1;
            item_next.placed = 1'b1;
        end else if (entered) begin
            item_next.nx    = code[0] ? xm : in_item.nx;
            item_next.ny    = code[1] ? in_item.ny : ym;
            item_next.nw    = kw;
            item_next.nh    = kh;
            item_next.level = lvl_idx + LVL_W'(1);
            // Codes of levels past the field width shift out and are lost.
            item_next.path  = in_item.path |
                              ({{(PATH_W-2){1'b0}}, code} << {lvl_idx, 1'b0});
        end else begin
            item_next.done   = 1'b1;
            item_next.placed = node_fits;
        end

        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[verif/qtnp_placement_checker.sv]
// Checker for the quadtree node placement block: keeps a copy of the root box
// registers, predicts the node of every rectangle beat and compares the results.
// Depends on qtnp_pkg for the beat types, register indexes and child codes.

module qtnp_placement_checker
    import qtnp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire in_beat_t             s_beat,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire out_beat_t            m_beat,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [FIELD_W-1:0]   cfg_wdata,
    output int                        mismatches,
    output int                        outstanding,
    output int                        checked,
    output int                        placed_total
);

    localparam longint SCALE = longint'(1) << MAX_DEPTH;

    // Root box in Q16.8 as last written, and the subdivision limit.
    longint      box_x, box_y, box_w, box_h;
    int unsigned split_limit;

    out_beat_t placements_due[$];
    out_beat_t want;
    int        err_count   = 0;
    int        seen        = 0;
    int        placed_seen = 0;

    // Inclusive containment of rectangle (rx, ry)-(rr, rt) in box q.
    function automatic bit encloses(input longint qx, qy, qw, qh, rx, ry, rr, rt);
        longint qr, qt;
        qr = qx + qw;
        qt = qy + qh;
        return !(rx < qx || ry < qy || rx > qr || ry > qt ||
                 rr < qx || rt < qy || rr > qr || rt > qt);
    endfunction

    function automatic out_beat_t place_rect(input in_beat_t r);
        longint            rx, ry, rr, rt, nx, ny, nw, nh, kw, kh, cx, cy;
        int                lim, lvl, i;
        bit                entered;
        child_t            kid;
        logic [PATH_W-1:0] path;
        out_beat_t         res;
        lim = (split_limit > MAX_DEPTH) ? MAX_DEPTH : int'(split_limit);
        rx  = longint'($signed(r.rect_x)) * SCALE;
        ry  = longint'($signed(r.rect_y)) * SCALE;
        rr  = rx + longint'(r.rect_width) * SCALE;
        rt  = ry + longint'(r.rect_height) * SCALE;
        nx  = box_x * SCALE;
        ny  = box_y * SCALE;
        nw  = box_w * SCALE;
        nh  = box_h * SCALE;
        lvl  = 0;
        path = '0;
        res  = '0;
        forever begin
            if (lvl >= lim) begin
                res.placed = 1'b1;
                break;
            end
            kw = nw >> 1;
            kh = nh >> 1;
            entered = 1'b0;
            // Child codes run in the order the children are tried.
            for (i = 0; i < 4; i++) begin
                kid = child_t'(i);
                cx = (kid == CHILD_TR || kid == CHILD_BR) ? nx + kw : nx;
                cy = (kid == CHILD_BL || kid == CHILD_BR) ? ny : ny + kh;
                if (encloses(cx, cy, kw, kh, rx, ry, rr, rt)) begin
                    entered = 1'b1;
                    break;
                end
            end
            if (!entered) begin
                res.placed = encloses(nx, ny, nw, nh, rx, ry, rr, rt);
                break;
            end
            path[2*lvl +: 2] = kid;
            lvl++;
            nx = cx;
            ny = cy;
            nw = kw;
            nh = kh;
        end
        if (res.placed) begin
            res.node_level = LVL_W'(lvl);
            res.node_path  = path;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            box_x       = 0;
            box_y       = 0;
            box_w       = 262144;
            box_h       = 262144;
            split_limit = 4;
            placements_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_ROOT_X:      box_x = longint'($signed(cfg_wdata));
                    REG_ROOT_Y:      box_y = longint'($signed(cfg_wdata));
                    REG_ROOT_WIDTH:  box_w = longint'(cfg_wdata);
                    REG_ROOT_HEIGHT: box_h = longint'(cfg_wdata);
                    REG_DEPTH_LIMIT: split_limit = int'(cfg_wdata[3:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                placements_due.insert(placements_due.size(), place_rect(s_beat));
            if (m_valid && m_ready) begin
                if (placements_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result placed=%0d level=%0d path=%h",
                                 $time, m_beat.placed, m_beat.node_level, m_beat.node_path);
                end else begin
                    want = placements_due.pop_front();
                    seen++;
                    if (m_beat.placed)
                        placed_seen++;
                    if (m_beat.placed !== want.placed ||
                        m_beat.node_level !== want.node_level ||
                        m_beat.node_path !== want.node_path) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"%0t: result %0d expected placed=%0d level=%0d ",
                                      "path=%h, got placed=%0d level=%0d path=%h"},
                                     $time, seen, want.placed, want.node_level,
                                     want.node_path, m_beat.placed, m_beat.node_level,
                                     m_beat.node_path);
                    end
                end
            end
        end
        mismatches   <= err_count;
        outstanding  <= placements_due.size();
        checked      <= seen;
        placed_total <= placed_seen;
    end

endmodule

[verif/quadtree_node_placement_top_test.sv]
// Testbench top for the quadtree node placement block: clock, reset, register
// programming and rectangle stimulus, with the verdict at the end.
// Depends on qtnp_pkg, quadtree_node_placement_top and qtnp_placement_checker.

module quadtree_node_placement_top_test;
    import qtnp_pkg::*;

    // All inputs of the block start at known values; reset is held low from time zero.
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_beat    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_beat;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [FIELD_W-1:0]   cfg_wdata = '0;

    int fail_total, in_flight, results_seen, results_placed;

    // When set, neither side idles; one phase runs this way to keep the pipe full.
    bit steady = 1'b0;

    // The root box as last programmed. The stimulus uses it only to aim rectangles
    // at the tree's cells and edges; prediction lives in the checker.
    longint cur_x = 0, cur_y = 0, cur_w = 262144, cur_h = 262144;
    int     cur_d = 4;
    int     settings_used = 1;

    quadtree_node_placement_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    qtnp_placement_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_beat       (s_beat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_beat       (m_beat),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (fail_total),
        .outstanding  (in_flight),
        .checked      (results_seen),
        .placed_total (results_placed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The result side stalls about 29 times in a hundred, except in the steady phase.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 29);
    end

    // Safety net: far beyond the slowest correct run, random gaps and stalls included.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [FIELD_W-1:0] clamp_s(input longint v);
        if (v < -longint'(8388608))
            v = -8388608;
        else if (v > 8388607)
            v = 8388607;
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_u(input longint v);
        if (v < 0)
            v = 0;
        else if (v > 16777215)
            v = 16777215;
        return v[FIELD_W-1:0];
    endfunction

    function automatic in_beat_t rect(input longint x, y, w, h);
        in_beat_t b;
        b.rect_x      = clamp_s(x);
        b.rect_y      = clamp_s(y);
        b.rect_width  = clamp_u(w);
        b.rect_height = clamp_u(h);
        return b;
    endfunction

    // Random rectangles, shaped so that most of them reach deep into the tree.
    // Most sit inside one cell of a random level, so they descend to that level
    // or below; some lie exactly on the grid lines of a level, where the inclusive
    // bounds and the order in which the children are tried decide; some hug the
    // root's edges; the rest are raw bit patterns.
    function automatic in_beat_t make_rect();
        int unsigned pick, lvl, lim;
        longint      cw, ch, x, y, w, h;
        lim  = (cur_d > MAX_DEPTH) ? MAX_DEPTH : cur_d;
        pick = $urandom_range(99);
        lvl  = $urandom_range(lim + 1);
        cw   = cur_w >> lvl;
        ch   = cur_h >> lvl;
        if (pick < 55) begin
            w = longint'($urandom_range(32'(cw)));
            h = longint'($urandom_range(32'(ch)));
            x = cur_x + cw * longint'($urandom_range((1 << lvl) - 1))
                + longint'($urandom_range(32'(cw - w)));
            y = cur_y + ch * longint'($urandom_range((1 << lvl) - 1))
                + longint'($urandom_range(32'(ch - h)));
        end else if (pick < 75) begin
            w = cw * longint'($urandom_range(2));
            h = ch * longint'($urandom_range(2));
            x = cur_x + cw * longint'($urandom_range(1 << lvl));
            y = cur_y + ch * longint'($urandom_range(1 << lvl));
        end else if (pick < 85) begin
            x = ($urandom_range(1) ? cur_x : cur_x + cur_w) + longint'($urandom_range(4)) - 2;
            y = ($urandom_range(1) ? cur_y : cur_y + cur_h) + longint'($urandom_range(4)) - 2;
            w = longint'($urandom_range(8));
            h = longint'($urandom_range(8));
        end else begin
            return in_beat_t'({$urandom, $urandom, $urandom});
        end
        return rect(x, y, w, h);
    endfunction

    // Offers one rectangle beat, after a random gap unless steady, and holds it until taken.
    task automatic send_rect(input in_beat_t b);
        if (!steady) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_beat  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_rect(make_rect());
    endtask

    // Lets every outstanding result drain before the registers change. Every beat
    // gives a result, but the task still waits out the pipeline depth after that.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0)
            @(posedge aclk);
        repeat (MAX_DEPTH + 2) @(posedge aclk);
    endtask

    // Raises the write enable for one write; the caller lowers it after its last write
    // so that back-to-back writes never drop the enable in between.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Programs a whole root box. The depth write carries random upper bits, which
    // the block must ignore, and one write to an unused index must change nothing.
    task automatic apply_settings(input longint x, y, w, h, input int d);
        logic [FIELD_W-1:0] depth_word;
        depth_word      = FIELD_W'($urandom);
        depth_word[3:0] = 4'(d);
        wait_drained();
        write_reg(REG_ROOT_X, clamp_s(x));
        write_reg(REG_ROOT_Y, clamp_s(y));
        write_reg(REG_ROOT_WIDTH, clamp_u(w));
        write_reg(REG_ROOT_HEIGHT, clamp_u(h));
        write_reg(REG_DEPTH_LIMIT, depth_word);
        write_reg(CFG_IDX_W'(REG_DEPTH_LIMIT) + CFG_IDX_W'($urandom_range(1, 3)),
                  FIELD_W'($urandom));
        cfg_we <= 1'b0;
        cur_x = longint'($signed(clamp_s(x)));
        cur_y = longint'($signed(clamp_s(y)));
        cur_w = longint'(clamp_u(w));
        cur_h = longint'(clamp_u(h));
        cur_d = d & 15;
        settings_used++;
    endtask

    initial begin
        longint rw, rh;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset box: origin at zero, 1024.0 on a side, four levels.
        send_rect(rect(0, 0, 262144, 262144));              // exactly the root
        send_rect(rect(0, 0, 0, 0));                        // bottom-left corner point
        send_rect(rect(131072, 131072, 0, 0));              // center point, first child wins
        send_rect(rect(262144, 262144, 0, 0));              // top-right corner point
        send_rect(rect(0, 262144, 0, 0));                   // top-left corner point
        send_rect(rect(262144, 0, 0, 0));                   // bottom-right corner point
        send_rect(rect(120000, 120000, 20000, 20000));      // straddles the center
        send_rect(rect(-256, 0, 512, 512));                 // partly outside, dropped
        send_rect(rect(-1, 0, 0, 0));                       // just left of the root
        send_rect(rect(8388607, 8388607, 0, 0));            // largest corner, dropped
        send_rect(rect(-8388608, -8388608, 16777215, 16777215));
        send_rect(rect(0, 0, 16777215, 0));                 // widest rectangle
        send_rect(rect(1000, 200000, 100, 100));            // one per quadrant
        send_rect(rect(200000, 200000, 100, 100));
        send_rect(rect(1000, 1000, 100, 100));
        send_rect(rect(200000, 1000, 100, 100));
        send_rect(rect(0, 131072, 131072, 131072));         // exactly the top-left child
        send_rect(rect(131072, 131072, 131072, 131072));    // exactly the top-right child
        send_rect(rect(0, 262144, 262144, 0));              // the root's top edge
        send_rect(rect(262145, 0, 0, 0));                   // just right of the root
        send_random(100);

        // Widest root box at full depth: the corner points give the longest paths
        // of each child kind, so every bit of the path field is exercised.
        apply_settings(-8388608, -8388608, 16777215, 16777215, 8);
        send_rect(rect(-8388608, -8388608, 0, 0));
        send_rect(rect(8388607, 8388607, 0, 0));
        send_rect(rect(-8388608, 8388607, 0, 0));
        send_rect(rect(8388607, -8388608, 0, 0));
        send_rect(rect(-8388608, -8388608, 16777215, 16777215));
        send_random(150);

        // No subdivision: everything is placed at the root, even far outside it.
        apply_settings(8388607, 8388607, 0, 0, 0);
        send_rect(rect(-8388608, -8388608, 16777215, 16777215));
        send_rect(rect(0, 0, 0, 0));
        send_random(60);

        // A root of zero size: only the single point on it can be kept.
        apply_settings(0, 0, 0, 0, 3);
        send_rect(rect(0, 0, 0, 0));
        send_rect(rect(0, 0, 1, 0));
        send_random(60);

        // Depth limit beyond the deepest tree saturates; this phase runs with the
        // channels never idling, so one rectangle goes in every cycle.
        apply_settings(-65536, 4096, 262144, 131072, 15);
        steady = 1'b1;
        send_random(120);
        steady = 1'b0;

        apply_settings(longint'($signed(FIELD_W'($urandom))), -8388608,
                       longint'($urandom_range(16777215)), 16777215, 9);
        send_random(100);

        // Random root boxes: sizes that halve evenly for a while, or any width at all.
        repeat (5) begin
            rw = $urandom_range(1) ? (longint'(256) << $urandom_range(14, 6))
                                   : longint'($urandom_range(16777215));
            rh = $urandom_range(1) ? rw : longint'($urandom_range(16777215));
            apply_settings(longint'($urandom_range(8388608)) - 4194304,
                           longint'($urandom_range(8388608)) - 4194304,
                           rw, rh, $urandom_range(15));
            send_random(80);
        end

        wait_drained();
        $display("Covered %0d root box settings with %0d rectangles: %0d placed, %0d dropped.",
                 settings_used, results_seen, results_placed, results_seen - results_placed);
        if (fail_total == 0 && in_flight == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[quadtree_node_placement_top.f]
hdl/qtnp_pkg.sv
hdl/qtnp_cell.sv
hdl/quadtree_node_placement_top.sv
verif/qtnp_placement_checker.sv
verif/quadtree_node_placement_top_test.sv
